>>> sv/aesp_pkg.sv
// shared codes for the escape sequence parser: parser modes, action codes, byte values
// no dependencies
`timescale 1ns / 1ps

package aesp_pkg;

    // parser mode codes
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ESC       = 3'd1;
    localparam logic [2:0] MODE_CSI       = 3'd2;
    localparam logic [2:0] MODE_P2        = 3'd3;
    localparam logic [2:0] MODE_TITLE_PRE = 3'd4;
    localparam logic [2:0] MODE_TITLE     = 3'd5;
    localparam logic [2:0] MODE_TITLE_END = 3'd6;

    // action codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_PRINT    = 3'd1;
    localparam logic [2:0] ACT_BELL     = 3'd2;
    localparam logic [2:0] ACT_LEFT     = 3'd3;
    localparam logic [2:0] ACT_EOL      = 3'd4;
    localparam logic [2:0] ACT_SCREEN   = 3'd5;
    localparam logic [2:0] ACT_POSITION = 3'd6;
    localparam logic [2:0] ACT_ATTR     = 3'd7;

    // character values
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_D         = 8'h44;
    localparam logic [7:0] CH_H         = 8'h48;
    localparam logic [7:0] CH_J         = 8'h4A;
    localparam logic [7:0] CH_K         = 8'h4B;
    localparam logic [7:0] CH_M_LOWER   = 8'h6D;

    // result field width on the stream
    localparam int OUT_PARAM_W = 16;

    typedef logic [2:0] action_t;

endpackage

>>> sv/aesp_step.sv
// next-state logic of the escape parser: mode transition, parameter update, action
// depends on aesp_pkg
`timescale 1ns / 1ps

module aesp_step
    import aesp_pkg::*;
#(
    parameter int PARAM_WIDTH = 16
)
(
    input  logic [2:0]             mode,
    input  logic [PARAM_WIDTH-1:0] param_one,
    input  logic [PARAM_WIDTH-1:0] param_two,
    input  logic [7:0]             code_byte,
    output logic [2:0]             mode_next,
    output logic [PARAM_WIDTH-1:0] param_one_next,
    output logic [PARAM_WIDTH-1:0] param_two_next,
    output action_t                action
);

    localparam int ACC_W = PARAM_WIDTH + 4;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [ACC_W-1:0]       acc_src;
    logic [ACC_W-1:0]       acc_sum;
    logic [PARAM_WIDTH-1:0] acc_sat;
    logic [2:0]             final_action;
    logic                   second_sel;

    // digit decode
    assign is_digit = (code_byte >= CH_ZERO) && (code_byte <= CH_NINE);
    assign digit    = 4'(code_byte - CH_ZERO);

    // times ten plus digit with saturation, on whichever parameter is being built
    assign second_sel = (mode == MODE_P2);
    assign acc_src    = second_sel ? ACC_W'(param_two) : ACC_W'(param_one);
    assign acc_sum    = (acc_src << 3) + (acc_src << 1) + ACC_W'(digit);
    assign acc_sat    = (acc_sum[ACC_W-1:PARAM_WIDTH] != '0) ? {PARAM_WIDTH{1'b1}}
                                                           : acc_sum[PARAM_WIDTH-1:0];

    // final byte decode for a control sequence
    always_comb
    begin
        unique case (code_byte)
            CH_K:       final_action = ACT_EOL;
            CH_J:       final_action = (param_one == PARAM_WIDTH'(2)) ? ACT_SCREEN : ACT_NONE;
            CH_D:       final_action = ACT_LEFT;
            CH_H:       final_action = ACT_POSITION;
            CH_M_LOWER: final_action = ACT_ATTR;
            default:    final_action = ACT_NONE;
        endcase
    end

    // mode transition
    always_comb
    begin
        mode_next      = mode;
        param_one_next = param_one;
        param_two_next = param_two;
        action         = ACT_NONE;
        unique case (mode)
            MODE_ESC:
            begin
                if (code_byte == CH_LBRACKET)
                begin
                    mode_next      = MODE_CSI;
                    param_one_next = '0;
                    param_two_next = '0;
                end
                else if (code_byte == CH_RBRACKET)
                begin
                    mode_next = MODE_TITLE_PRE;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_CSI:
            begin
                if (code_byte == CH_SEMI)
                begin
                    mode_next = MODE_P2;
                end
                else if (is_digit)
                begin
                    param_one_next = acc_sat;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    action    = final_action;
                end
            end
            MODE_P2:
            begin
                if (is_digit)
                begin
                    param_two_next = acc_sat;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    action    = final_action;
                end
            end
            MODE_TITLE_PRE:
            begin
                if (code_byte == CH_SEMI)
                begin
                    mode_next = MODE_TITLE;
                end
                else if (code_byte == CH_ESC)
                begin
                    mode_next = MODE_TITLE_END;
                end
            end
            MODE_TITLE:
            begin
                if (code_byte == CH_ESC)
                begin
                    mode_next = MODE_TITLE_END;
                end
            end
            MODE_TITLE_END:
            begin
                mode_next = (code_byte == CH_BACKSLASH) ? MODE_NORMAL : MODE_TITLE;
            end
            default:
            begin
                // normal mode, unused code treated the same
                mode_next = MODE_NORMAL;
                if (code_byte == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else if (code_byte == CH_BEL)
                begin
                    action = ACT_BELL;
                end
                else if (code_byte == CH_BS)
                begin
                    param_one_next = PARAM_WIDTH'(1);
                    action         = ACT_LEFT;
                end
                else
                begin
                    action = ACT_PRINT;
                end
            end
        endcase
    end

endmodule

>>> sv/ansi_escape_sequence_parser_core.sv
// top level of the escape sequence parser: input register, parser state, result register
// depends on aesp_pkg and aesp_step
`timescale 1ns / 1ps
//
// usage
//   input stream s_*: one terminal byte per transaction in s_tdata[7:0]
//   output stream m_*: exactly one result per input byte, in order; m_tdata holds
//   the action code, then the first and second parameter (low 16 bits each)
//   path: an accepted byte is held in the input register, parsed by the step logic
//   and its result is captured in the result register, which drives m_*
//   throughput: one byte per cycle while m_tready is high, set by the parse step that
//   updates mode and parameters between the input and the result register
//   stall: while m_tready is low the result holds; one further byte may be taken
//   into the input register, after which s_tready drops until the result leaves
//   reset: rst_n clears both valid flags, the mode to normal and both
//   parameters to zero
//   PARAM_WIDTH sets the width of the internal parameter accumulators, which
//   saturate at their all-ones value; the result fields carry their low 16 bits
//
module ansi_escape_sequence_parser_core
    import aesp_pkg::*;
#(
    parameter int PARAM_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] action, [18:3] first_param, [34:19] second_param
);

    localparam int EXT_W = PARAM_WIDTH + OUT_PARAM_W;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic [2:0]             mode_reg;
    logic [2:0]             mode_next;
    logic [PARAM_WIDTH-1:0] param_one_reg;
    logic [PARAM_WIDTH-1:0] param_one_next;
    logic [PARAM_WIDTH-1:0] param_two_reg;
    logic [PARAM_WIDTH-1:0] param_two_next;
    action_t                action;
    logic                   out_valid_reg;
    action_t                out_action_reg;
    logic [OUT_PARAM_W-1:0] out_first_reg;
    logic [OUT_PARAM_W-1:0] out_second_reg;
    logic [EXT_W-1:0]       first_ext;
    logic [EXT_W-1:0]       second_ext;
    logic                   advance;

    // handshake: the parse step moves when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // parse step
    aesp_step #(
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_step (
        .mode           (mode_reg),
        .param_one      (param_one_reg),
        .param_two      (param_two_reg),
        .code_byte      (in_byte_reg),
        .mode_next      (mode_next),
        .param_one_next (param_one_next),
        .param_two_next (param_two_next),
        .action         (action)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            param_one_reg <= '0;
            param_two_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            param_one_reg <= param_one_next;
            param_two_reg <= param_two_next;
        end
    end

    // parameters fitted to the result field width
    assign first_ext  = EXT_W'(param_one_next);
    assign second_ext = EXT_W'(param_two_next);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_action_reg <= action;
            out_first_reg  <= first_ext[OUT_PARAM_W-1:0];
            out_second_reg <= second_ext[OUT_PARAM_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_second_reg, out_first_reg, out_action_reg};

endmodule
